// ===== hdl/clcp_pkg.sv =====
// Shared types, codes and compare tables for the code lock / climate PWM controller.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package clcp_pkg;

	localparam int unsigned ENTRY_LIMIT = 99;
	localparam int unsigned CODE_LEN    = 4;

	localparam logic [15:0] PASSCODE_RST = 16'h6985;

	// command byte ranges
	localparam logic [7:0] LIGHT_BASE = 8'd100;
	localparam logic [7:0] KEY_BASE   = 8'd200;

	// keypad keys with a function of their own
	localparam logic [5:0] KEY_SUBMIT = 6'd10;
	localparam logic [5:0] KEY_ERASE  = 6'd11;
	localparam logic [5:0] KEY_TOGGLE = 6'd12;

	typedef enum logic [1:0] {
		OUTCOME_NONE  = 2'd0,
		OUTCOME_GRANT = 2'd1,
		OUTCOME_DENY  = 2'd2
	} outcome_t;

	typedef enum logic [1:0] {
		BLINK_NONE = 2'd0,
		BLINK_HOT  = 2'd1,
		BLINK_COLD = 2'd2
	} blink_t;

	typedef struct packed {
		logic       unlocked;
		outcome_t   outcome;
		logic [6:0] entry_count;
	} lock_res_t;

	typedef struct packed {
		logic [6:0] last_temperature;
		logic [8:0] cooler_compare;
		logic [7:0] heater_compare;
		logic [7:0] lamp_compare;
		blink_t     blink_select;
	} clim_res_t;

	typedef struct packed {
		lock_res_t lock;
		clim_res_t clim;
	} result_t;

	// floor(duty * 255 / 100) for cooler duty 50 + 10 * floor((t - 25) / 5), t in 25..55
	function automatic logic [8:0] cooler_cmp(input logic [6:0] t);
		logic [8:0] c;
		if (t < 7'd30)      c = 9'd127;
		else if (t < 7'd35) c = 9'd153;
		else if (t < 7'd40) c = 9'd178;
		else if (t < 7'd45) c = 9'd204;
		else if (t < 7'd50) c = 9'd229;
		else if (t < 7'd55) c = 9'd255;
		else                c = 9'd280;
		return c;
	endfunction

	// heater duty 100 - 25 * floor(t / 5), t in 3..20
	function automatic logic [7:0] heater_cmp(input logic [6:0] t);
		logic [7:0] c;
		if (t < 7'd5)       c = 8'd255;
		else if (t < 7'd10) c = 8'd191;
		else if (t < 7'd15) c = 8'd127;
		else if (t < 7'd20) c = 8'd63;
		else                c = 8'd0;
		return c;
	endfunction

	function automatic logic [7:0] lamp_cmp(input logic [6:0] v);
		logic [7:0] c;
		if (v <= 7'd25)      c = 8'd255;
		else if (v <= 7'd50) c = 8'd191;
		else if (v <= 7'd75) c = 8'd127;
		else                 c = 8'd63;
		return c;
	endfunction

endpackage

`default_nettype wire

// ===== hdl/clcp_lock.sv =====
// Code lock: passcode register, entry buffer, entry counter and unlock flag.
// Uses clcp_pkg. Gives the lock fields of the result as they stand after the beat.
`timescale 1ns / 1ps
`default_nettype none

module clcp_lock (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  passcode_we,
	input  wire [15:0]           passcode,
	input  wire                  accept,
	input  wire [7:0]            command_byte,
	output logic                 unlocked_now,
	output clcp_pkg::lock_res_t  res
);
	import clcp_pkg::*;

	logic [15:0] passcode_q;
	logic        unlock_q;
	logic [6:0]  entry_cnt_q;
	logic [5:0]  entry_q [CODE_LEN];

	logic       is_key;
	logic [5:0] key;
	logic       do_submit;
	logic       do_erase;
	logic       do_entry;
	logic       code_ok;
	logic       unlock_nxt;
	logic [6:0] cnt_nxt;
	outcome_t   outcome;

	assign is_key = (command_byte >= KEY_BASE) && !unlock_q;
	assign key    = 6'(command_byte - KEY_BASE);

	assign do_submit = is_key && (key == KEY_SUBMIT);
	assign do_erase  = is_key && (key == KEY_ERASE);
	assign do_entry  = is_key && (key != KEY_SUBMIT) && (key != KEY_ERASE)
		&& (key != KEY_TOGGLE) && (entry_cnt_q < 7'(ENTRY_LIMIT));

	always_comb begin
		code_ok = (entry_cnt_q == 7'(CODE_LEN));
		for (int i = 0; i < CODE_LEN; i++) begin
			if (passcode_q[15 - 4*i -: 4] > 4'd9 ||
				entry_q[i] != {2'b00, passcode_q[15 - 4*i -: 4]}) begin
				code_ok = 1'b0;
			end
		end
	end

	always_comb begin
		unlock_nxt = unlock_q;
		cnt_nxt    = entry_cnt_q;
		outcome    = OUTCOME_NONE;
		if (do_submit) begin
			cnt_nxt = '0;
			if (code_ok) begin
				unlock_nxt = 1'b1;
				outcome    = OUTCOME_GRANT;
			end else begin
				outcome = OUTCOME_DENY;
			end
		end else if (do_erase) begin
			if (entry_cnt_q != '0) cnt_nxt = entry_cnt_q - 7'd1;
		end else if (do_entry) begin
			cnt_nxt = entry_cnt_q + 7'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			passcode_q  <= PASSCODE_RST;
			unlock_q    <= 1'b0;
			entry_cnt_q <= '0;
		end else begin
			if (passcode_we) passcode_q <= passcode;
			if (accept) begin
				unlock_q    <= unlock_nxt;
				entry_cnt_q <= cnt_nxt;
			end
		end
	end

	// only the first four positions are kept
	always_ff @(posedge clk) begin
		if (accept && do_entry && entry_cnt_q < 7'(CODE_LEN)) begin
			entry_q[entry_cnt_q[1:0]] <= key;
		end
	end

	assign unlocked_now    = unlock_q;
	assign res.unlocked    = unlock_nxt;
	assign res.outcome     = outcome;
	assign res.entry_count = cnt_nxt;

	a_unlock_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		!$fell(unlock_q))
		else $error("unlock flag dropped");

	a_cnt_limit: assert property (@(posedge clk) disable iff (!arst_n)
		entry_cnt_q <= 7'(ENTRY_LIMIT))
		else $error("entry count above limit");

	a_submit_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accept && do_submit |=> entry_cnt_q == '0)
		else $error("submit did not clear entries");

	a_unlock_needs_grant: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !unlock_q && !(do_submit && code_ok) |=> !unlock_q)
		else $error("unlocked without a matching submit");

endmodule

`default_nettype wire

// ===== hdl/clcp_climate.sv =====
// Climate and lamp control: temperature, cooler/heater/lamp compares and blink select.
// Uses clcp_pkg compare tables. Gives the climate fields as they stand after the beat.
`timescale 1ns / 1ps
`default_nettype none

module clcp_climate (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  accept,
	input  wire [7:0]            command_byte,
	input  wire                  unlocked_now,
	output clcp_pkg::clim_res_t  res
);
	import clcp_pkg::*;

	clim_res_t state_q;
	clim_res_t state_nxt;

	logic       is_temp;
	logic       is_light;
	logic [6:0] t;
	logic [6:0] v;

	assign is_temp  = command_byte < LIGHT_BASE;
	assign is_light = !is_temp && command_byte < KEY_BASE;
	assign t        = command_byte[6:0];
	assign v        = 7'(command_byte - LIGHT_BASE);

	always_comb begin
		state_nxt = state_q;
		if (is_temp) begin
			state_nxt.last_temperature = t;
			if (unlocked_now) begin
				if (t >= 7'd25 && t <= 7'd55) begin
					state_nxt.cooler_compare = cooler_cmp(t);
					state_nxt.heater_compare = '0;
				end else if (t >= 7'd3 && t <= 7'd20) begin
					state_nxt.cooler_compare = '0;
					state_nxt.heater_compare = heater_cmp(t);
				end else if (t > 7'd55 || t < 7'd3) begin
					state_nxt.cooler_compare = '0;
					state_nxt.heater_compare = '0;
				end
				if (t > 7'd55)     state_nxt.blink_select = BLINK_HOT;
				else if (t < 7'd3) state_nxt.blink_select = BLINK_COLD;
				else               state_nxt.blink_select = BLINK_NONE;
			end
		end else if (is_light && unlocked_now) begin
			state_nxt.lamp_compare = lamp_cmp(v);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.last_temperature <= '0;
			state_q.cooler_compare   <= '0;
			state_q.heater_compare   <= '0;
			state_q.lamp_compare     <= '0;
			state_q.blink_select     <= BLINK_NONE;
		end else if (accept) begin
			state_q <= state_nxt;
		end
	end

	assign res = state_nxt;

	a_lock_holds_pwm: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !unlocked_now |=> $stable(state_q.cooler_compare)
			&& $stable(state_q.lamp_compare) && $stable(state_q.blink_select))
		else $error("PWM state moved while locked");

	a_one_output_on: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.cooler_compare == '0 || state_q.heater_compare == '0)
		else $error("cooler and heater both driven");

	a_blink_off_pwm: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.blink_select != BLINK_NONE |-> state_q.cooler_compare == '0
			&& state_q.heater_compare == '0)
		else $error("warning blink with a PWM active");

endmodule

`default_nettype wire

// ===== hdl/clcp_outbuf.sv =====
// Two-entry result buffer between the update logic and the output channel.
// Uses clcp_pkg result type. Keeps input accepting while a result waits.
`timescale 1ns / 1ps
`default_nettype none

module clcp_outbuf (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                push,
	input  wire clcp_pkg::result_t din,
	output logic               full,
	output logic               out_valid,
	input  wire                out_stall,
	output clcp_pkg::result_t  dout
);
	import clcp_pkg::*;

	result_t slot0_q;
	result_t slot1_q;
	logic    v0_q;
	logic    v1_q;
	logic    pop;

	assign pop = v0_q && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v0_q <= 1'b0;
			v1_q <= 1'b0;
		end else begin
			if (v1_q) begin
				if (pop) v1_q <= 1'b0;
			end else if (v0_q) begin
				if (push && !pop) v1_q <= 1'b1;
				else if (pop && !push) v0_q <= 1'b0;
			end else if (push) begin
				v0_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (v1_q) begin
			if (pop) slot0_q <= slot1_q;
		end else if (v0_q) begin
			if (push && pop) slot0_q <= din;
			else if (push)   slot1_q <= din;
		end else if (push) begin
			slot0_q <= din;
		end
	end

	assign full      = v1_q;
	assign out_valid = v0_q;
	assign dout      = slot0_q;

	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		v1_q |-> v0_q)
		else $error("second slot filled ahead of first");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		v1_q |-> !push)
		else $error("beat pushed into full buffer");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		v1_q && pop |=> v0_q && !v1_q)
		else $error("buffer drain lost a beat");

endmodule

`default_nettype wire

// ===== hdl/code_lock_climate_pwm_controller_top.sv =====
// A result enters the output buffer when its command byte is taken and reaches the port from the buffer's head slot.
// Throughput: one command byte per cycle while the buffer is not full; lock and climate update as each byte is taken.
// A two-entry output buffer holds results; input stalls only when both entries wait.
// Reset (arst_n low, asynchronous): locked, counters and PWM compares zero,
// passcode 0x6985, output buffer empty. Code entries are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module code_lock_climate_pwm_controller_top (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         passcode_we,
	input  wire  [15:0] passcode,
	input  wire         in_valid,
	output logic        in_stall,
	input  wire  [7:0]  command_byte,
	output logic        out_valid,
	input  wire         out_stall,
	output logic        unlocked,
	output logic [1:0]  attempt_outcome,
	output logic [6:0]  entry_count,
	output logic [6:0]  last_temperature,
	output logic [8:0]  cooler_compare,
	output logic [7:0]  heater_compare,
	output logic [7:0]  lamp_compare,
	output logic [1:0]  blink_select
);
	import clcp_pkg::*;

	logic    accept;
	logic    full;
	logic    unlocked_now;
	result_t res;
	result_t head;

	assign in_stall = full;
	assign accept   = in_valid && !full;

	clcp_lock u_lock (
		.clk          (clk),
		.arst_n       (arst_n),
		.passcode_we  (passcode_we),
		.passcode     (passcode),
		.accept       (accept),
		.command_byte (command_byte),
		.unlocked_now (unlocked_now),
		.res          (res.lock)
	);

	clcp_climate u_climate (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.command_byte (command_byte),
		.unlocked_now (unlocked_now),
		.res          (res.clim)
	);

	clcp_outbuf u_outbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.din       (res),
		.full      (full),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.dout      (head)
	);

	assign unlocked         = head.lock.unlocked;
	assign attempt_outcome  = head.lock.outcome;
	assign entry_count      = head.lock.entry_count;
	assign last_temperature = head.clim.last_temperature;
	assign cooler_compare   = head.clim.cooler_compare;
	assign heater_compare   = head.clim.heater_compare;
	assign lamp_compare     = head.clim.lamp_compare;
	assign blink_select     = head.clim.blink_select;

endmodule

`default_nettype wire
